FILE: design/gmf_pkg.sv
// Shared types, codes and helpers of the grayscale morphology filter.
package gmf_pkg;

  localparam int PIX_W           = 8;
  localparam int MAX_FRAME_LINES = 1024;
  localparam int ROW_W           = 10;
  localparam int HGT_W           = 11;
  localparam int OUT_DEPTH       = 4;
  localparam int OUT_PTR_W       = 2;

  // register indexes (byte address / 4)
  localparam logic [2:0] REG_MODE   = 3'd0;
  localparam logic [2:0] REG_SHAPE  = 3'd1;
  localparam logic [2:0] REG_WINDOW = 3'd2;
  localparam logic [2:0] REG_WIDTH  = 3'd3;
  localparam logic [2:0] REG_HEIGHT = 3'd4;

  // structuring element codes
  localparam logic [1:0] SHAPE_SQUARE  = 2'd0;
  localparam logic [1:0] SHAPE_DIAMOND = 2'd1;
  localparam logic [1:0] SHAPE_ROW     = 2'd2;
  localparam logic [1:0] SHAPE_BYPASS  = 2'd3;

  localparam logic MODE_ERODE  = 1'b0;
  localparam logic MODE_DILATE = 1'b1;

  typedef struct packed {
    logic       shift;
    logic       mode;
    logic [1:0] shape;
    logic [4:0] win;
  } cell_ctrl_t;

  typedef struct packed {
    logic             valid;
    logic             zero;
    logic             pass;
    logic             last;
    logic [PIX_W-1:0] pixel;
  } sb_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             last;
  } out_entry_t;

  function automatic logic [PIX_W-1:0] identity(input logic mode);
    return (mode == MODE_DILATE) ? '0 : '1;
  endfunction

  function automatic logic [PIX_W-1:0] pick(input logic mode,
                                            input logic [PIX_W-1:0] a,
                                            input logic [PIX_W-1:0] b);
    if (mode == MODE_DILATE) return (a > b) ? a : b;
    return (a < b) ? a : b;
  endfunction

endpackage

FILE: design/gmf_cell.sv
// One window row: optional line delay memory, row of window taps and masked row reduction.
module gmf_cell #(
  parameter int MAX_WINDOW     = 21,
  parameter int MAX_LINE_WIDTH = 1024,
  parameter int ROW            = 0,
  parameter bit HAS_LINE       = 1'b1
) (
  input  logic                                clk,
  input  gmf_pkg::cell_ctrl_t                 ctrl,
  input  logic [$clog2(MAX_LINE_WIDTH)-1:0]   wr_col,
  input  logic [$clog2(MAX_LINE_WIDTH)-1:0]   rd_col,
  input  logic [gmf_pkg::PIX_W-1:0]           pix_in,
  output logic [gmf_pkg::PIX_W-1:0]           line_out,
  output logic [gmf_pkg::PIX_W-1:0]           row_result
);

  localparam int TREE_LVL = $clog2(MAX_WINDOW);
  localparam int TREE_N   = 1 << TREE_LVL;

  logic [gmf_pkg::PIX_W-1:0] taps [MAX_WINDOW];
  logic [MAX_WINDOW-1:0]     mask;
  logic [MAX_WINDOW-1:0]     mask_next;
  logic [gmf_pkg::PIX_W-1:0] lv [TREE_LVL+1][TREE_N];

  // shift the newest pixel in at tap 0
  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      taps[0] <= pix_in;
      for (int k = 1; k < MAX_WINDOW; k++) begin
        taps[k] <= taps[k-1];
      end
    end
  end

  always_comb begin
    int m;
    int hh;
    int dr;
    int dc;
    m  = int'(ctrl.win);
    hh = m / 2;
    dr = (ROW > hh) ? ROW - hh : hh - ROW;
    for (int k = 0; k < MAX_WINDOW; k++) begin
      dc = (k > hh) ? k - hh : hh - k;
      unique case (ctrl.shape)
        gmf_pkg::SHAPE_SQUARE:  mask_next[k] = (ROW < m) && (k < m);
        gmf_pkg::SHAPE_DIAMOND: mask_next[k] = (dr + dc <= hh);
        gmf_pkg::SHAPE_ROW:     mask_next[k] = (ROW == 0) && (k < m);
        default:                mask_next[k] = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    mask <= mask_next;
  end

  // balanced compare tree over the row
  always_comb begin
    for (int l = 0; l <= TREE_LVL; l++) begin
      for (int i = 0; i < TREE_N; i++) begin
        lv[l][i] = gmf_pkg::identity(ctrl.mode);
      end
    end
    for (int k = 0; k < MAX_WINDOW; k++) begin
      if (mask[k]) lv[0][k] = taps[k];
    end
    for (int l = 0; l < TREE_LVL; l++) begin
      for (int i = 0; i < TREE_N / 2; i++) begin
        lv[l+1][i] = gmf_pkg::pick(ctrl.mode, lv[l][2*i], lv[l][2*i+1]);
      end
    end
  end

  always_ff @(posedge clk) begin
    row_result <= lv[TREE_LVL][0];
  end

  generate
    if (HAS_LINE) begin : g_line
      logic [gmf_pkg::PIX_W-1:0] line_mem [MAX_LINE_WIDTH];
      logic [gmf_pkg::PIX_W-1:0] rd_q;
      always_ff @(posedge clk) begin
        if (ctrl.shift) line_mem[wr_col] <= pix_in;
        rd_q <= line_mem[rd_col];
      end
      assign line_out = rd_q;
    end else begin : g_noline
      assign line_out = '0;
    end
  endgenerate

endmodule

FILE: design/gmf_out_stage.sv
// Column reduction of the row results and the output queue.
module gmf_out_stage #(
  parameter int MAX_WINDOW = 21
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        mode,
  input  logic [gmf_pkg::PIX_W-1:0]   row_res [MAX_WINDOW],
  input  gmf_pkg::sb_t                sb,
  output logic [gmf_pkg::OUT_PTR_W:0] fill,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [7:0]                  m_tdata,
  output logic                        m_tlast
);

  localparam int TREE_LVL = $clog2(MAX_WINDOW);
  localparam int TREE_N   = 1 << TREE_LVL;

  logic [gmf_pkg::PIX_W-1:0]     lv [TREE_LVL+1][TREE_N];
  gmf_pkg::out_entry_t           queue [gmf_pkg::OUT_DEPTH];
  gmf_pkg::out_entry_t           entry;
  logic [gmf_pkg::OUT_PTR_W-1:0] wptr;
  logic [gmf_pkg::OUT_PTR_W-1:0] rptr;
  logic                          push;
  logic                          pop;

  always_comb begin
    for (int l = 0; l <= TREE_LVL; l++) begin
      for (int i = 0; i < TREE_N; i++) begin
        lv[l][i] = gmf_pkg::identity(mode);
      end
    end
    for (int k = 0; k < MAX_WINDOW; k++) begin
      lv[0][k] = row_res[k];
    end
    for (int l = 0; l < TREE_LVL; l++) begin
      for (int i = 0; i < TREE_N / 2; i++) begin
        lv[l+1][i] = gmf_pkg::pick(mode, lv[l][2*i], lv[l][2*i+1]);
      end
    end
  end

  always_comb begin
    entry.last = sb.last;
    priority if (sb.pass) begin
      entry.pixel = sb.pixel;
    end else if (sb.zero) begin
      entry.pixel = '0;
    end else begin
      entry.pixel = lv[TREE_LVL][0];
    end
  end

  assign push     = sb.valid;
  assign m_tvalid = (fill != '0);
  assign pop      = m_tvalid && m_tready;
  assign m_tdata  = queue[rptr].pixel;
  assign m_tlast  = queue[rptr].last;

  always_ff @(posedge clk) begin
    if (push) queue[wptr] <= entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop)  rptr <= rptr + 1'b1;
      fill <= fill + (gmf_pkg::OUT_PTR_W+1)'(push) - (gmf_pkg::OUT_PTR_W+1)'(pop);
    end
  end

endmodule

FILE: design/grayscale_morphology_filter_core.sv
// Top level of the grayscale erosion / dilation window filter.
// Pixels of one 8-bit plane enter in raster order, one per clock while
// s_tready is high (s_tdata = pixel, s_tuser = flush). Each result is the
// minimum (erosion) or maximum (dilation) over a square or diamond element
// centred on the output pixel, or over a row element starting at it and
// reaching right; positions where the element does not fit give 0, and shape
// code 3 passes pixels through. A result for position p leaves once pixel
// p + half*width + half (row element: p + window - 1) is in; flush beats after
// the last pixel of the frame push out the remaining results, m_tlast marks
// the frame's final one. The block takes one transaction per clock while
// s_tready is high; s_tready drops once queued and in-flight results fill the
// four-entry output queue. An accepted pixel is registered into the window
// taps, the per-row compare trees are registered, and the column compare tree
// feeds the output queue. Line history lives in MAX_WINDOW-1 line memories,
// one in each cell but the last, each read every clock and written on each
// accepted pixel. Registers (APB, byte address 4*i): mode, shape, window size,
// width, height; a write to one of them abandons the frame in progress.
module grayscale_morphology_filter_core #(
  parameter int MAX_LINE_WIDTH = 1024,
  parameter int MAX_WINDOW     = 21
) (
  input  logic        clk,
  input  logic        rst,
  // slave stream: tdata[7:0] pixel_in; tuser[0] flush
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic        s_tuser,
  // master stream: tdata[7:0] pixel_out; tlast last_of_frame
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,
  output logic        m_tlast,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int COL_W = $clog2(MAX_LINE_WIDTH);
  localparam int WID_W = $clog2(MAX_LINE_WIDTH + 1);
  localparam int LAG_W = $clog2((MAX_WINDOW / 2) * MAX_LINE_WIDTH + MAX_WINDOW + 2);

  // configuration registers
  logic       operation_mode;
  logic [1:0] element_shape;
  logic [4:0] window_size;
  logic [10:0] frame_width;
  logic [10:0] frame_height;

  // frame counters
  logic [COL_W-1:0]          in_column;
  logic [gmf_pkg::ROW_W-1:0] in_row;
  logic [COL_W-1:0]          out_col;
  logic [gmf_pkg::ROW_W-1:0] out_row;
  logic [LAG_W-1:0]          lag;
  logic                      input_done;

  logic [COL_W-1:0]          col_next;
  logic [gmf_pkg::ROW_W-1:0] row_next;
  logic [COL_W-1:0]          out_col_next;
  logic [gmf_pkg::ROW_W-1:0] out_row_next;
  logic [LAG_W-1:0]          lag_next;
  logic                      done_next;

  logic [WID_W-1:0]          eff_w;
  logic [gmf_pkg::HGT_W-1:0] eff_h;
  logic [4:0]                eff_m;
  logic [3:0]                half;
  logic [LAG_W-1:0]          delay;
  logic [LAG_W-1:0]          lag_pre;

  logic cfg_wr;
  logic cfg_hit;
  logic accept;
  logic is_pix;
  logic col_wrap;
  logic row_wrap;
  logic done_after;
  logic emit;
  logic last_pos;
  logic zero_pos;

  gmf_pkg::sb_t       sb0;
  gmf_pkg::sb_t       sb1;
  gmf_pkg::cell_ctrl_t ctrl;
  logic [gmf_pkg::OUT_PTR_W:0] fill;

  logic [gmf_pkg::PIX_W-1:0] chain   [MAX_WINDOW];
  logic [gmf_pkg::PIX_W-1:0] row_res [MAX_WINDOW];

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  // only a write that lands on a register restarts the frame
  assign cfg_hit = cfg_wr && (paddr[4:2] <= gmf_pkg::REG_HEIGHT);

  always_comb begin
    unique case (paddr[4:2])
      gmf_pkg::REG_MODE:   prdata = 32'(operation_mode);
      gmf_pkg::REG_SHAPE:  prdata = 32'(element_shape);
      gmf_pkg::REG_WINDOW: prdata = 32'(window_size);
      gmf_pkg::REG_WIDTH:  prdata = 32'(frame_width);
      gmf_pkg::REG_HEIGHT: prdata = 32'(frame_height);
      default:             prdata = '0;
    endcase
  end

  // clamp the registers to usable values
  always_comb begin
    int w;
    priority if (frame_width == '0) begin
      eff_w = WID_W'(1);
    end else if (int'(frame_width) > MAX_LINE_WIDTH) begin
      eff_w = WID_W'(MAX_LINE_WIDTH);
    end else begin
      eff_w = WID_W'(frame_width);
    end
    priority if (frame_height == '0) begin
      eff_h = gmf_pkg::HGT_W'(1);
    end else if (int'(frame_height) > gmf_pkg::MAX_FRAME_LINES) begin
      eff_h = gmf_pkg::HGT_W'(gmf_pkg::MAX_FRAME_LINES);
    end else begin
      eff_h = frame_height;
    end
    w = int'(window_size);
    if (w < 3) w = 3;
    if (w > MAX_WINDOW) w = MAX_WINDOW;
    w = w | 1;
    if (w > MAX_WINDOW) w = w - 2;
    eff_m = 5'(w);
    half  = 4'(w / 2);
  end

  always_comb begin
    unique case (element_shape)
      gmf_pkg::SHAPE_SQUARE,
      gmf_pkg::SHAPE_DIAMOND: delay = LAG_W'(int'(half) * int'(eff_w) + int'(half));
      gmf_pkg::SHAPE_ROW:     delay = LAG_W'(int'(eff_m) - 1);
      default:                delay = '0;
    endcase
  end

  // per-transaction step of the frame counters
  assign s_tready = (int'(fill) + int'(sb0.valid) + int'(sb1.valid)) < gmf_pkg::OUT_DEPTH;
  assign accept   = s_tvalid && s_tready;
  assign is_pix   = !s_tuser && !input_done;
  assign col_wrap = (int'(in_column) + 1) >= int'(eff_w);
  assign row_wrap = (int'(in_row) + 1) >= int'(eff_h);
  assign done_after = input_done || (is_pix && col_wrap && row_wrap);
  assign lag_pre  = lag + LAG_W'(is_pix);
  assign emit     = done_after || (lag_pre > delay);
  assign last_pos = (int'(out_row) == int'(eff_h) - 1) && (int'(out_col) == int'(eff_w) - 1);

  // give 0 for results where the element leaves the frame
  always_comb begin
    int r;
    int c;
    int hh;
    r  = int'(out_row);
    c  = int'(out_col);
    hh = int'(half);
    unique case (element_shape)
      gmf_pkg::SHAPE_SQUARE,
      gmf_pkg::SHAPE_DIAMOND: zero_pos = (r < hh) || (c < hh) ||
                                         (r + hh > int'(eff_h) - 1) ||
                                         (c + hh > int'(eff_w) - 1);
      gmf_pkg::SHAPE_ROW:     zero_pos = (c + int'(eff_m) - 1 > int'(eff_w) - 1);
      default:                zero_pos = 1'b0;
    endcase
  end

  always_comb begin
    col_next     = in_column;
    row_next     = in_row;
    done_next    = input_done;
    lag_next     = lag;
    out_col_next = out_col;
    out_row_next = out_row;
    if (cfg_hit) begin
      col_next     = '0;
      row_next     = '0;
      done_next    = 1'b0;
      lag_next     = '0;
      out_col_next = '0;
      out_row_next = '0;
    end else if (accept) begin
      lag_next = lag_pre;
      if (is_pix) begin
        if (col_wrap) begin
          col_next = '0;
          row_next = row_wrap ? '0 : in_row + 1'b1;
        end else begin
          col_next = in_column + 1'b1;
        end
        done_next = done_after;
      end
      if (emit) begin
        lag_next = lag_pre - 1'b1;
        if (int'(out_col) + 1 >= int'(eff_w)) begin
          out_col_next = '0;
          out_row_next = out_row + 1'b1;
        end else begin
          out_col_next = out_col + 1'b1;
        end
        // frame complete: rewind for the next one
        if (last_pos) begin
          col_next     = '0;
          row_next     = '0;
          done_next    = 1'b0;
          lag_next     = '0;
          out_col_next = '0;
          out_row_next = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      operation_mode <= gmf_pkg::MODE_ERODE;
      element_shape  <= gmf_pkg::SHAPE_SQUARE;
      window_size    <= 5'd3;
      frame_width    <= 11'd640;
      frame_height   <= 11'd480;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        gmf_pkg::REG_MODE:   operation_mode <= pwdata[0];
        gmf_pkg::REG_SHAPE:  element_shape  <= pwdata[1:0];
        gmf_pkg::REG_WINDOW: window_size    <= pwdata[4:0];
        gmf_pkg::REG_WIDTH:  frame_width    <= pwdata[10:0];
        gmf_pkg::REG_HEIGHT: frame_height   <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_column  <= '0;
      in_row     <= '0;
      input_done <= 1'b0;
      lag        <= '0;
      out_col    <= '0;
      out_row    <= '0;
    end else begin
      in_column  <= col_next;
      in_row     <= row_next;
      input_done <= done_next;
      lag        <= lag_next;
      out_col    <= out_col_next;
      out_row    <= out_row_next;
    end
  end

  // sideband travels alongside the window pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      sb0.valid <= 1'b0;
      sb1.valid <= 1'b0;
    end else begin
      sb0.valid <= accept && emit && !cfg_hit;
      sb1.valid <= sb0.valid;
    end
    sb0.zero  <= zero_pos;
    sb0.pass  <= (element_shape == gmf_pkg::SHAPE_BYPASS);
    sb0.last  <= last_pos;
    sb0.pixel <= s_tdata;
    sb1.zero  <= sb0.zero;
    sb1.pass  <= sb0.pass;
    sb1.last  <= sb0.last;
    sb1.pixel <= sb0.pixel;
  end

  always_comb begin
    ctrl.shift = accept && is_pix && !cfg_hit;
    ctrl.mode  = operation_mode;
    ctrl.shape = element_shape;
    ctrl.win   = eff_m;
  end

  // cell j holds image row R-j; each hands its delayed line to the next
  genvar j;
  generate
    for (j = 0; j < MAX_WINDOW; j++) begin : g_cell
      gmf_cell #(
        .MAX_WINDOW     (MAX_WINDOW),
        .MAX_LINE_WIDTH (MAX_LINE_WIDTH),
        .ROW            (j),
        .HAS_LINE       (j < MAX_WINDOW - 1)
      ) u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .wr_col     (in_column),
        .rd_col     (col_next),
        .pix_in     ((j == 0) ? s_tdata : chain[(j == 0) ? 0 : j - 1]),
        .line_out   (chain[j]),
        .row_result (row_res[j])
      );
    end
  endgenerate

  gmf_out_stage #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_out (
    .clk      (clk),
    .rst      (rst),
    .mode     (operation_mode),
    .row_res  (row_res),
    .sb       (sb1),
    .fill     (fill),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

`ifndef SYNTHESIS
  a_credit : assert property (@(posedge clk) disable iff (rst)
    (int'(fill) + int'(sb0.valid) + int'(sb1.valid)) <= gmf_pkg::OUT_DEPTH)
    else $error("output queue overcommitted");

  a_done_rewound : assert property (@(posedge clk) disable iff (rst)
    input_done |-> (in_column == '0) && (in_row == '0))
    else $error("input counters not rewound at frame end");

  a_last_rewind : assert property (@(posedge clk) disable iff (rst)
    (accept && emit && last_pos && !cfg_hit) |=>
      (out_row == '0) && (out_col == '0) && !input_done && (lag == '0))
    else $error("frame end did not rewind counters");

  a_cfg_restart : assert property (@(posedge clk) disable iff (rst)
    cfg_hit |=> (in_column == '0) && (out_col == '0) && !sb0.valid)
    else $error("register write did not restart the frame");
`endif

endmodule
